[rtl/core/kmh_pkg.sv]
// Package for the keyed max-heap priority queue.
// Holds the word types, action and status codes and default sizes; no dependencies.
package kmh_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int TIME_BITS_DEF = 16;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_PEEK   = 2'd1;
    localparam logic [1:0] ACT_UPDATE = 2'd2;
    localparam logic [1:0] ACT_DRAIN  = 2'd3;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_ABSENT = 3'd1;
    localparam logic [2:0] ST_NEVER  = 3'd2;
    localparam logic [2:0] ST_FULL   = 3'd3;
    localparam logic [2:0] ST_EMPTY  = 3'd4;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  severity;
        logic [15:0] arrival_time;
        logic [15:0] patient_id;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] entry_id;
        logic [3:0]  entry_severity;
        logic [15:0] entry_arrival;
        logic        last;
    } rsp_t;

endpackage

[rtl/core/keyed_max_heap_priority_queue_top.sv]
// Top level of the keyed priority queue: sequencer, result register and entry store.
// Depends on kmh_pkg and kmh_mem.
//
//  channel | direction | handshake                | word
//  req     | in        | req_valid / req_ready    | kmh_pkg::req_t
//  rsp     | out       | rsp_valid / rsp_ready    | kmh_pkg::rsp_t
//
// One request word is taken at a time; req_ready is high only while the sequencer is idle.
// Entries are kept sorted by priority in the store, highest first; peek reads the top entry.
// Insert shifts lower-ranked entries down and drops the key into the hole; update scans
// every id, then runs an insertion-sort pass; drain emits every entry, highest first.
// Reset clears the entry count and sets the id counter to one; no clearing pass is run.
// A full result register stalls the sequencer until rsp_ready frees it.
module keyed_max_heap_priority_queue_top #(
    parameter int CAPACITY  = kmh_pkg::CAPACITY_DEF,
    parameter int TIME_BITS = kmh_pkg::TIME_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  kmh_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output kmh_pkg::rsp_t rsp
);

    import kmh_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = 20 + TIME_BITS;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_IRD  = 4'd1;
    localparam logic [3:0] S_ICMP = 4'd2;
    localparam logic [3:0] S_IPUT = 4'd3;
    localparam logic [3:0] S_ORD  = 4'd4;
    localparam logic [3:0] S_OKEY = 4'd5;
    localparam logic [3:0] S_URD  = 4'd6;
    localparam logic [3:0] S_UCHK = 4'd7;
    localparam logic [3:0] S_PK   = 4'd8;
    localparam logic [3:0] S_DRD  = 4'd9;
    localparam logic [3:0] S_DOUT = 4'd10;
    localparam logic [3:0] S_EMIT = 4'd11;

    logic [3:0]           state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [15:0]          next_id_reg, next_id_next;
    logic [CW-1:0]        i_reg, i_next;
    logic [AW-1:0]        j_reg, j_next;
    logic                 sort_reg, sort_next;
    logic                 found_reg, found_next;
    logic [15:0]          key_id_reg, key_id_next;
    logic [3:0]           key_sev_reg, key_sev_next;
    logic [TIME_BITS-1:0] key_arr_reg, key_arr_next;
    logic [15:0]          pid_reg, pid_next;
    rsp_t                 res_reg, res_next;
    rsp_t                 out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;

    logic                 we, re;
    logic [AW-1:0]        waddr, raddr;
    logic [EW-1:0]        wdata, rdata;
    logic [15:0]          r_id;
    logic [3:0]           r_sev;
    logic [TIME_BITS-1:0] r_arr;
    logic                 key_above;
    logic                 slot_free;
    logic                 accept;
    logic [TIME_BITS-1:0] in_arr;
    logic [CW-1:0]        i_inc;
    logic [CW-1:0]        count_m1;

    kmh_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (EW),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign r_id  = rdata[EW-1 -: 16];
    assign r_sev = rdata[TIME_BITS +: 4];
    assign r_arr = rdata[TIME_BITS-1:0];

    // The held key outranks the stored entry: higher severity, then earlier arrival,
    // then smaller id.
    assign key_above = (key_sev_reg > r_sev) ||
                       ((key_sev_reg == r_sev) &&
                        ((key_arr_reg < r_arr) ||
                         ((key_arr_reg == r_arr) && (key_id_reg < r_id))));

    assign slot_free = !out_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign in_arr    = TIME_BITS'(req.arrival_time);
    assign i_inc     = i_reg + CW'(1);
    assign count_m1  = count_reg - CW'(1);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        next_id_next   = next_id_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        sort_next      = sort_reg;
        found_next     = found_reg;
        key_id_next    = key_id_reg;
        key_sev_next   = key_sev_reg;
        key_arr_next   = key_arr_reg;
        pid_next       = pid_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        we             = 1'b0;
        waddr          = '0;
        wdata          = {key_id_reg, key_sev_reg, key_arr_reg};
        re             = 1'b0;
        raddr          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next       = '0;
                    res_next.last  = 1'b1;
                    pid_next       = req.patient_id;
                    key_sev_next   = req.severity;
                    i_next         = '0;
                    found_next     = 1'b0;
                    sort_next      = 1'b0;
                    case (req.action)
                        ACT_INSERT:
                        begin
                            if (count_reg >= CW'(CAPACITY))
                            begin
                                res_next.status = ST_FULL;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                key_id_next             = next_id_reg;
                                key_arr_next            = in_arr;
                                res_next.status         = ST_OK;
                                res_next.entry_id       = next_id_reg;
                                res_next.entry_severity = req.severity;
                                res_next.entry_arrival  = 16'(in_arr);
                                next_id_next            = next_id_reg + 16'd1;
                                count_next              = count_reg + CW'(1);
                                j_next                  = AW'(count_m1);
                                state_next = (count_reg == '0) ? S_IPUT : S_IRD;
                            end
                        end
                        ACT_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = ST_EMPTY;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                re         = 1'b1;
                                state_next = S_PK;
                            end
                        end
                        ACT_UPDATE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status   = (next_id_reg > req.patient_id) ?
                                                    ST_ABSENT : ST_NEVER;
                                res_next.entry_id = req.patient_id;
                                state_next        = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_URD;
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = ST_EMPTY;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_DRD;
                            end
                        end
                    endcase
                end
            end

            S_IRD:
            begin
                re         = 1'b1;
                raddr      = j_reg;
                state_next = S_ICMP;
            end

            // Insertion step: shift the compared entry one place down while the key
            // outranks it, otherwise drop the key into the hole.
            S_ICMP:
            begin
                we    = 1'b1;
                waddr = j_reg + AW'(1);
                if (key_above)
                begin
                    wdata = rdata;
                    if (j_reg == '0)
                    begin
                        state_next = S_IPUT;
                    end
                    else
                    begin
                        re     = 1'b1;
                        raddr  = j_reg - AW'(1);
                        j_next = j_reg - AW'(1);
                    end
                end
                else
                begin
                    i_next = i_inc;
                    if (sort_reg && (i_inc < count_reg))
                    begin
                        state_next = S_ORD;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end

            S_IPUT:
            begin
                we     = 1'b1;
                waddr  = '0;
                i_next = i_inc;
                if (sort_reg && (i_inc < count_reg))
                begin
                    state_next = S_ORD;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end

            S_ORD:
            begin
                re         = 1'b1;
                raddr      = AW'(i_reg);
                state_next = S_OKEY;
            end

            S_OKEY:
            begin
                key_id_next  = r_id;
                key_sev_next = r_sev;
                key_arr_next = r_arr;
                re           = 1'b1;
                raddr        = AW'(i_reg - CW'(1));
                j_next       = AW'(i_reg - CW'(1));
                state_next   = S_ICMP;
            end

            S_URD:
            begin
                re         = 1'b1;
                raddr      = AW'(i_reg);
                state_next = S_UCHK;
            end

            // Every entry with the matching id takes the new severity; the arrival of
            // the last match is reported.
            S_UCHK:
            begin
                i_next = i_inc;
                if (r_id == pid_reg)
                begin
                    we                     = 1'b1;
                    waddr                  = AW'(i_reg);
                    wdata                  = {r_id, key_sev_reg, r_arr};
                    found_next             = 1'b1;
                    res_next.entry_arrival = 16'(r_arr);
                end
                if (i_inc < count_reg)
                begin
                    state_next = S_URD;
                end
                else if (found_next)
                begin
                    res_next.status         = ST_OK;
                    res_next.entry_id       = pid_reg;
                    res_next.entry_severity = key_sev_reg;
                    sort_next               = 1'b1;
                    i_next                  = CW'(1);
                    state_next = (count_reg > CW'(1)) ? S_ORD : S_EMIT;
                end
                else
                begin
                    res_next.status   = (next_id_reg > pid_reg) ? ST_ABSENT : ST_NEVER;
                    res_next.entry_id = pid_reg;
                    state_next        = S_EMIT;
                end
            end

            S_PK:
            begin
                res_next.status         = ST_OK;
                res_next.entry_id       = r_id;
                res_next.entry_severity = r_sev;
                res_next.entry_arrival  = 16'(r_arr);
                state_next              = S_EMIT;
            end

            S_DRD:
            begin
                re         = 1'b1;
                raddr      = AW'(i_reg);
                state_next = S_DOUT;
            end

            S_DOUT:
            begin
                if (slot_free)
                begin
                    out_valid_next          = 1'b1;
                    out_next.status         = ST_OK;
                    out_next.entry_id       = r_id;
                    out_next.entry_severity = r_sev;
                    out_next.entry_arrival  = 16'(r_arr);
                    out_next.last           = (i_reg == count_m1);
                    i_next                  = i_inc;
                    state_next = (i_reg == count_m1) ? S_IDLE : S_DRD;
                end
            end

            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            next_id_reg   <= 16'd1;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            sort_reg      <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            next_id_reg   <= next_id_next;
            out_valid_reg <= out_valid_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            sort_reg      <= sort_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_id_reg  <= key_id_next;
        key_sev_reg <= key_sev_next;
        key_arr_reg <= key_arr_next;
        pid_reg     <= pid_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.action == ACT_INSERT) && (count_reg < CW'(CAPACITY)))
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the entry count");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> ((state_reg == S_ICMP) || (state_reg == S_IPUT) || (state_reg == S_UCHK)))
        else $error("store written outside insert or update");

    a_drain_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DOUT) |-> (count_reg != '0))
        else $error("drain running on an empty store");
`endif

endmodule

[rtl/core/kmh_mem.sv]
// Entry store: synchronous RAM with one write port and one registered read port.
// Uses no package items; sized by the top level.
module kmh_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 36,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds its value until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
